@@ rtl/sawtc_pkg.sv @@
// Shared types and constants for the set-associative write-through cache.
package sawtc_pkg;

   localparam int ADDR_BITS  = 16;
   localparam int TAG_BITS   = ADDR_BITS - 13;
   localparam int WAYS       = 8;
   localparam int WAY_BITS   = 3;
   localparam int SET_BITS   = 7;
   localparam int OFF_BITS   = 6;
   localparam int LINE_LEN   = 64;
   localparam int LFSR_BITS  = 16;

   localparam logic [OFF_BITS-1:0]  EDGE_OFFSET = 6'h3c;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED   = 16'hace1;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [1:0]  size_code;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        cache_hit;
   } rsp_type;

   typedef struct packed {
      logic [WAYS-1:0]               valid;
      logic [WAYS-1:0][TAG_BITS-1:0] tag;
   } row_type;

   typedef struct packed {
      logic                 clear;
      logic                 load;
      logic                 row_rd;
      logic                 look;
      logic                 inval;
      logic                 fill_done;
      logic                 mem_wr;
      logic                 mem_rd;
      logic                 fill_rd;
      logic                 fill_wr;
      logic                 line_rd;
      logic                 cap_mem;
      logic                 cap_line;
      logic                 rsp_ld;
      logic [ADDR_BITS-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic       is_write;
      logic       bypass;
      logic       hit_now;
      logic [2:0] len;
   } status_type;

endpackage

@@ rtl/set_assoc_write_through_cache_core.sv @@
// Top level of the 8-way write-through cache in front of a byte-addressed memory.
//
// Requests arrive on req_valid/req_stall/req_word, one word per access; the
// response (read data and hit flag) leaves on rsp_valid/rsp_stall/rsp_word.
// One access is worked at a time; req_stall is low only while idle.
// Byte loops per access:
//   write:             size bytes, one backing byte written per cycle
//   read hit/bypass:   size bytes, one byte read per cycle
//   read miss:         64-byte line fill, byte per cycle, then the size bytes
// where size is 1, 2 or 4 bytes; byte-wide single-port memories set these rates.
// The next access can be accepted in the cycle after the previous one hands off.
// After reset the block sweeps all 65536 backing bytes to zero and
// clears every set's valid bits, one address per cycle, holding req_stall
// high until the sweep ends. A finished response sits in an output register;
// while the receiver stalls it holds, and the next access is still accepted
// but completes only once the register is free.
module set_assoc_write_through_cache_core import sawtc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   cmd_type    cmd;
   status_type status;

   sawtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sawtc_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

@@ rtl/sawtc_dpath.sv @@
// Datapath: backing memory, line data, tag/valid rows, replacement LFSR and response word.
module sawtc_dpath import sawtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_word,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_word
);

   logic [7:0]    mem [2**ADDR_BITS];
   logic [7:0]    line_mem [2**(SET_BITS+WAY_BITS+OFF_BITS)];
   row_type       row_mem [2**SET_BITS];

   req_type                req_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic                   hit_ff, hit_in;
   logic [WAY_BITS-1:0]    way_ff, way_in;
   logic [LFSR_BITS-1:0]   lfsr_ff, lfsr_in;
   logic [31:0]            rdata_ff;
   rsp_type                rsp_ff;
   logic [7:0]             mem_q, line_q;
   row_type                row_q;

   logic [OFF_BITS-1:0]    off;
   logic [SET_BITS-1:0]    set;
   logic [TAG_BITS-1:0]    tag;
   logic [ADDR_BITS-1:0]   prev;
   logic                   hit_now, all_valid;
   logic [WAY_BITS-1:0]    hit_way, free_way, victim;
   logic                   lfsr_bit;

   logic [ADDR_BITS-1:0]   mem_a;
   logic                   mem_we;
   logic [7:0]             mem_wd;
   logic [SET_BITS+WAY_BITS+OFF_BITS-1:0] line_wa, line_ra;
   logic                   line_we;
   logic [7:0]             line_wd;
   logic                   row_we;
   logic [SET_BITS-1:0]    row_a;
   row_type                row_wd;

   assign off  = addr_ff[OFF_BITS-1:0];
   assign set  = addr_ff[OFF_BITS +: SET_BITS];
   assign tag  = addr_ff[ADDR_BITS-1 -: TAG_BITS];
   assign prev = cmd.idx - ADDR_BITS'(1);

   // Lowest matching way wins; first invalid way is the preferred victim.
   always_comb begin
      hit_now   = 1'b0;
      hit_way   = '0;
      free_way  = '0;
      all_valid = 1'b1;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_q.valid[w] && row_q.tag[w] == tag) begin
            hit_now = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!row_q.valid[w]) begin
            all_valid = 1'b0;
            free_way  = WAY_BITS'(w);
         end
      end
   end

   assign lfsr_bit = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];

   always_comb begin
      lfsr_in = lfsr_ff;
      victim  = free_way;
      if (all_valid) begin
         victim = lfsr_in[WAY_BITS-1:0];
      end
      if (cmd.look && req_ff.kind == KIND_READ && !status.bypass && !hit_now && all_valid)
      begin
         lfsr_in = {lfsr_bit, lfsr_ff[LFSR_BITS-1:1]};
         victim  = lfsr_in[WAY_BITS-1:0];
      end
      hit_in = hit_now && !(req_ff.kind == KIND_READ && status.bypass);
      way_in = hit_now ? hit_way : victim;
   end

   always_comb begin
      status.is_write = (req_ff.kind == KIND_WRITE);
      status.bypass   = (off >= EDGE_OFFSET);
      status.hit_now  = hit_now;
      unique case (req_ff.size_code)
         SIZE_BYTE: status.len = 3'd1;
         SIZE_HALF: status.len = 3'd2;
         default:   status.len = 3'd4;
      endcase
   end

   // Backing memory port.
   always_comb begin
      mem_we = cmd.clear || cmd.mem_wr;
      mem_wd = cmd.clear ? 8'h00 : req_ff.write_data[8*cmd.idx[1:0] +: 8];
      priority if (cmd.clear) begin
         mem_a = cmd.idx;
      end else if (cmd.fill_rd) begin
         mem_a = {addr_ff[ADDR_BITS-1:OFF_BITS], cmd.idx[OFF_BITS-1:0]};
      end else begin
         mem_a = addr_ff + cmd.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_a] <= mem_wd;
      end
      mem_q <= mem[mem_a];
   end

   // Line data port: fill bytes come from the previous backing read.
   always_comb begin
      line_we = cmd.fill_wr || (cmd.mem_wr && hit_ff && !status.bypass);
      if (cmd.fill_wr) begin
         line_wa = {set, way_ff, prev[OFF_BITS-1:0]};
         line_wd = mem_q;
      end else begin
         line_wa = {set, way_ff, off + cmd.idx[OFF_BITS-1:0]};
         line_wd = req_ff.write_data[8*cmd.idx[1:0] +: 8];
      end
      line_ra = {set, way_ff, off + cmd.idx[OFF_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_wa] <= line_wd;
      end
      line_q <= line_mem[line_ra];
   end

   // Tag and valid rows, one per set.
   always_comb begin
      row_we = cmd.clear || (cmd.inval && hit_now) || cmd.fill_done;
      row_a  = cmd.clear ? cmd.idx[SET_BITS-1:0] : set;
      row_wd = row_q;
      priority if (cmd.clear) begin
         row_wd = '0;
      end else if (cmd.fill_done) begin
         row_wd.valid[way_ff] = 1'b1;
         row_wd.tag[way_ff]   = tag;
      end else begin
         row_wd.valid[hit_way] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_a] <= row_wd;
      end
      if (cmd.row_rd) begin
         row_q <= row_mem[row_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_word;
         addr_ff  <= ADDR_BITS'(req_word.address);
         rdata_ff <= '0;
      end
      if (cmd.look) begin
         hit_ff <= hit_in;
         way_ff <= way_in;
      end
      if (cmd.cap_mem) begin
         rdata_ff[8*prev[1:0] +: 8] <= mem_q;
      end
      if (cmd.cap_line) begin
         rdata_ff[8*prev[1:0] +: 8] <= line_q;
      end
      if (cmd.rsp_ld) begin
         rsp_ff.read_data <= rdata_ff;
         rsp_ff.cache_hit <= hit_ff;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

@@ rtl/sawtc_ctrl.sv @@
// Controller: sequences memory clearing, lookup, byte loops, line fills and response hand-off.
module sawtc_ctrl import sawtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_TAGRD  = 4'd2;
   localparam logic [3:0] ST_LOOK   = 4'd3;
   localparam logic [3:0] ST_WRMEM  = 4'd4;
   localparam logic [3:0] ST_BYPRD  = 4'd5;
   localparam logic [3:0] ST_FILL   = 4'd6;
   localparam logic [3:0] ST_LINERD = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   localparam logic [ADDR_BITS-1:0] CNT_LAST = '1;
   localparam logic [ADDR_BITS-1:0] CNT_LINE = ADDR_BITS'(LINE_LEN);

   logic [3:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] len;
   logic                 slot_free;

   assign len       = ADDR_BITS'(status.len);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.idx      = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            cnt_in    = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TAGRD;
            end
         end
         ST_TAGRD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            cnt_in   = '0;
            priority if (status.is_write) begin
               cmd.inval = status.bypass;
               state_in  = ST_WRMEM;
            end else if (status.bypass) begin
               state_in = ST_BYPRD;
            end else if (status.hit_now) begin
               state_in = ST_LINERD;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_WRMEM: begin
            cmd.mem_wr = 1'b1;
            cnt_in     = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff == len - ADDR_BITS'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_BYPRD: begin
            cmd.mem_rd  = (cnt_ff < len);
            cmd.cap_mem = (cnt_ff != '0);
            cnt_in      = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff == len) begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            // Reads run one byte ahead of the line writes.
            cmd.fill_rd = (cnt_ff < CNT_LINE);
            cmd.fill_wr = (cnt_ff != '0);
            cnt_in      = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff == CNT_LINE) begin
               cmd.fill_done = 1'b1;
               cnt_in        = '0;
               state_in      = ST_LINERD;
            end
         end
         ST_LINERD: begin
            cmd.line_rd  = (cnt_ff < len);
            cmd.cap_line = (cnt_ff != '0);
            cnt_in       = cnt_ff + ADDR_BITS'(1);
            if (cnt_ff == len) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_look_after_tagrd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> ($past(state_ff) == ST_TAGRD))
      else $error("lookup without a row read");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_TAGRD))
      else $error("accepted word did not start a lookup");
   a_done_hands_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished word not handed to the response register");
   a_fill_to_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && cnt_ff == CNT_LINE) |=> (state_ff == ST_LINERD))
      else $error("line fill did not continue into the line read");
`endif

endmodule
